[design/pge_pkg.sv]
// Package for the bracket-group extractor: character codes, status codes
// and shared types. No dependencies.
package pge_pkg;

  typedef logic [7:0] char_t;
  typedef logic [1:0] status_t;

  // Bracket characters.
  localparam char_t OPEN_CHAR  = 8'h28;
  localparam char_t CLOSE_CHAR = 8'h29;

  // Result status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNMATCHED = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

endpackage

[design/pge_if.sv]
// Valid/ready channel interfaces for the bracket-group extractor.
// Depends on pge_pkg for the payload types.
interface pge_in_if;
  logic          valid;
  logic          ready;
  pge_pkg::char_t char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface pge_out_if;
  logic             valid;
  logic             ready;
  pge_pkg::char_t   char_out;
  logic             last_of_group;
  logic             empty_group;
  pge_pkg::status_t status;

  modport source (output valid, output char_out, output last_of_group,
                  output empty_group, output status, input ready);
  modport sink   (input valid, input char_out, input last_of_group,
                  input empty_group, input status, output ready);
endinterface

[design/pge_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/paren_group_extractor.sv]
// Top level of the bracket-group extractor: control sequencer around two
// stack memories. Depends on pge_pkg, pge_if (pge_in_if, pge_out_if), pge_ram.
//
// Usage:
//   in_chan carries one character per request. Any character other than ')'
//   is pushed and gives no result. A ')' closes the newest '(':
//   the sequencer first fetches that bracket's position from the bracket stack, then
//   the characters inside are read from the character stack and delivered on
//   out_chan one per cycle, oldest first, last_of_group set on the final one.
//   A closing bracket with nothing inside gives one result with empty_group.
//   A ')' with no open bracket, or a push onto a full stack, is dropped and
//   gives one result with the matching status code.
//   No new request is taken until a ')' has been fully read out; the character
//   stack's single read port limits the read-out to one character per cycle
//   while out_chan is ready.
//   Results pass through an output register; input is taken only when the
//   sequencer is idle and that register is free or being emptied.
//   A stall on out_chan freezes the read-out in place; nothing is lost.
//   Reset empties both stacks at once by clearing their counts; the memory
//   contents are not cleared.
module paren_group_extractor #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pge_in_if.sink    in_chan,
  pge_out_if.source out_chan
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POS  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] open_cnt_r, open_cnt_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] end_r, end_nxt;

  logic             out_valid_r, out_valid_nxt;
  pge_pkg::char_t   out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_empty_r, out_empty_nxt;
  pge_pkg::status_t out_status_r, out_status_nxt;

  logic           cmem_we, cmem_re;
  logic [IW-1:0]  cmem_waddr, cmem_raddr;
  pge_pkg::char_t cmem_rdata;
  logic           omem_we, omem_re;
  logic [IW-1:0]  omem_waddr, omem_raddr, omem_wdata, omem_rdata;

  logic          can_load, in_ready, accept, is_close;
  logic [CW-1:0] open_dec, first_idx, cur_inc;

  // Character stack and stack of open-bracket positions.
  pge_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (cmem_we),
    .waddr (cmem_waddr),
    .wdata (in_chan.char_in),
    .re    (cmem_re),
    .raddr (cmem_raddr),
    .rdata (cmem_rdata)
  );

  pge_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_open_ram (
    .clk   (clk),
    .we    (omem_we),
    .waddr (omem_waddr),
    .wdata (omem_wdata),
    .re    (omem_re),
    .raddr (omem_raddr),
    .rdata (omem_rdata)
  );

  // Handshake and helper values.
  assign can_load  = !out_valid_r || out_chan.ready;
  assign in_ready  = (state_r == S_IDLE) && can_load;
  assign accept    = in_chan.valid && in_ready;
  assign is_close  = (in_chan.char_in == pge_pkg::CLOSE_CHAR);
  assign open_dec  = open_cnt_r - CW'(1);
  assign first_idx = CW'(omem_rdata) + CW'(1);
  assign cur_inc   = cur_r + CW'(1);

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.char_out      = out_char_r;
  assign out_chan.last_of_group = out_last_r;
  assign out_chan.empty_group   = out_empty_r;
  assign out_chan.status        = out_status_r;

  // Sequencer: push, fetch the bracket position, then read the group out.
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    open_cnt_nxt   = open_cnt_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    cmem_we        = 1'b0;
    cmem_waddr     = top_r[IW-1:0];
    cmem_re        = 1'b0;
    cmem_raddr     = cur_inc[IW-1:0];
    omem_we        = 1'b0;
    omem_waddr     = open_cnt_r[IW-1:0];
    omem_wdata     = top_r[IW-1:0];
    omem_re        = 1'b0;
    omem_raddr     = open_dec[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!is_close) begin
            if (top_r == CW'(STACK_DEPTH)) begin
              out_valid_nxt  = 1'b1;
              out_char_nxt   = '0;
              out_last_nxt   = 1'b0;
              out_empty_nxt  = 1'b0;
              out_status_nxt = pge_pkg::ST_OVERFLOW;
            end else begin
              cmem_we = 1'b1;
              top_nxt = top_r + CW'(1);
              if (in_chan.char_in == pge_pkg::OPEN_CHAR) begin
                omem_we      = 1'b1;
                open_cnt_nxt = open_cnt_r + CW'(1);
              end
            end
          end else if (open_cnt_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = '0;
            out_last_nxt   = 1'b0;
            out_empty_nxt  = 1'b0;
            out_status_nxt = pge_pkg::ST_UNMATCHED;
          end else begin
            open_cnt_nxt = open_dec;
            omem_re      = 1'b1;
            state_nxt    = S_POS;
          end
        end
      end

      S_POS: begin
        // The output register was free or being emptied when the ')' was taken, so it is empty now.
        top_nxt = CW'(omem_rdata);
        if (first_idx >= top_r) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_empty_nxt  = 1'b1;
          out_status_nxt = pge_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          cmem_re    = 1'b1;
          cmem_raddr = first_idx[IW-1:0];
          cur_nxt    = first_idx;
          end_nxt    = top_r;
          state_nxt  = S_EMIT;
        end
      end

      S_EMIT: begin
        // Read data for cur_r stays put until the output register takes it.
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = cmem_rdata;
          out_last_nxt   = (cur_inc == end_r);
          out_empty_nxt  = 1'b0;
          out_status_nxt = pge_pkg::ST_OK;
          if (cur_inc == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            cmem_re = 1'b1;
            cur_nxt = cur_inc;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      open_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      open_cnt_r  <= open_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and read-out registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  // The stack never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CW'(STACK_DEPTH))
    else $error("character stack count beyond depth");

  // Every pending '(' sits on the character stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= top_r)
    else $error("more open brackets than stacked characters");

  // During read-out the index stays inside the group.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cur_r < end_r))
    else $error("read-out index past end of group");

  // A matched ')' always goes on to fetch its bracket position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_close && (open_cnt_r != '0)) |=> (state_r == S_POS))
    else $error("matched close bracket did not start a group");

  // The final result of a group returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && can_load && (cur_inc == end_r)) |=>
      (out_valid_r && out_last_r && (state_r == S_IDLE)))
    else $error("group end not delivered");

endmodule

[bench/testbench.sv]
// Self-checking bench for paren_group_extractor: random and directed character
// streams, with a scoreboard that predicts every closed group and flag result.
// Depends on pge_pkg, pge_if and the paren_group_extractor top level.
module testbench;

  localparam int DEPTH      = 64;
  localparam int WATCHDOG   = 8000;
  localparam int HOLD_OFF   = 300;
  localparam int DRAIN_WAIT = 20;

  typedef struct packed {
    pge_pkg::char_t   ch;
    logic             last;
    logic             empty;
    pge_pkg::status_t st;
  } group_result_t;

  // Tracks the character and bracket stacks and holds the results still owed.
  class paren_group_scoreboard;
    pge_pkg::char_t char_mem [DEPTH];
    logic [5:0]     open_mem [DEPTH];
    int unsigned    depth_used;
    int unsigned    opens;
    group_result_t  owed_results[$];
    int             errors;
    int             checked;

    function new();
      depth_used = 0;
      opens      = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void owe(pge_pkg::char_t ch, logic last, logic empty, pge_pkg::status_t st);
      group_result_t r;
      r.ch    = ch;
      r.last  = last;
      r.empty = empty;
      r.st    = st;
      owed_results = {owed_results, r};
    endfunction

    // Applies one accepted request to the stacks and queues what it causes.
    function void note_char(pge_pkg::char_t c);
      int unsigned pos;
      int unsigned first;
      if (c != pge_pkg::CLOSE_CHAR) begin
        if (depth_used >= DEPTH) begin
          owe(8'h00, 1'b0, 1'b0, pge_pkg::ST_OVERFLOW);
        end else begin
          if (c == pge_pkg::OPEN_CHAR && opens < DEPTH) begin
            open_mem[opens] = depth_used[5:0];
            opens++;
          end
          char_mem[depth_used] = c;
          depth_used++;
        end
      end else if (opens == 0) begin
        owe(8'h00, 1'b0, 1'b0, pge_pkg::ST_UNMATCHED);
      end else begin
        opens--;
        pos   = open_mem[opens];
        first = pos + 1;
        if (first >= depth_used) begin
          owe(8'h00, 1'b1, 1'b1, pge_pkg::ST_OK);
        end else begin
          for (int unsigned i = first; i < depth_used; i++)
            owe(char_mem[i], (i + 1 == depth_used), 1'b0, pge_pkg::ST_OK);
        end
        if (pos < depth_used) depth_used = pos;
      end
    endfunction

    // Compares one delivered result with the oldest one owed.
    function void check_result(group_result_t got);
      group_result_t exp;
      logic          bad;
      checked++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ch=%02h last=%b empty=%b status=%0d",
                 $time, got.ch, got.last, got.empty, got.st);
      end else begin
        exp = owed_results.pop_front();
        bad = (got.last != exp.last) || (got.empty != exp.empty) || (got.st != exp.st);
        // The character carries no meaning on an empty group.
        if (!exp.empty && got.ch != exp.ch) bad = 1'b1;
        if (bad) begin
          errors++;
          $display("%0t: mismatch expected ch=%02h last=%b empty=%b status=%0d,",
                   $time, exp.ch, exp.last, exp.empty, exp.st);
          $display("%0t:   actual ch=%02h last=%b empty=%b status=%0d",
                   $time, got.ch, got.last, got.empty, got.st);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_cycles = 0;
  bit   hold_done = 1'b0;

  paren_group_scoreboard groups = new();

  pge_in_if  in_chan();
  pge_out_if out_chan();

  paren_group_extractor #(.STACK_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one character after a random gap and waits for its acceptance.
  // Valid stays high between back-to-back requests.
  task automatic send_char(input pge_pkg::char_t c, input int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.char_in <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    groups.note_char(c);
  endtask

  function automatic pge_pkg::char_t plain_char();
    pge_pkg::char_t b;
    do b = pge_pkg::char_t'($urandom_range(0, 255));
    while (b == pge_pkg::OPEN_CHAR || b == pge_pkg::CLOSE_CHAR);
    return b;
  endfunction

  // Chooses the next character from the predicted stack state so that most of
  // the stream forms groups and junk below the outermost bracket stays small.
  function automatic pge_pkg::char_t pick_char(int close_pct);
    int r;
    r = $urandom_range(0, 99);
    if (groups.opens == 0) begin
      if (r < 55) return pge_pkg::OPEN_CHAR;
      if (r < 70) return pge_pkg::CLOSE_CHAR;
      if (groups.depth_used < 8) return pge_pkg::char_t'($urandom_range(0, 255));
      return pge_pkg::OPEN_CHAR;
    end
    if (groups.depth_used >= 56 && close_pct >= 10 && r < 90) return pge_pkg::CLOSE_CHAR;
    if (r < close_pct) return pge_pkg::CLOSE_CHAR;
    if (r < close_pct + 10) return pge_pkg::OPEN_CHAR;
    if (r < close_pct + 15) return pge_pkg::char_t'($urandom_range(0, 255));
    return plain_char();
  endfunction

  // Result receiver: random stalls, stretches without stalls, and one long
  // hold-off so that the block backs up and refuses requests.
  initial begin
    int gap;
    bit stalling;
    stalling = 1'b1;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) stalling = !stalling;
      gap = stalling ? $urandom_range(0, 18) : 0;
      if (!hold_done && groups.checked >= 40) begin
        gap       = HOLD_OFF;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      groups.check_result({out_chan.char_out, out_chan.last_of_group,
                           out_chan.empty_group, out_chan.status});
  end

  // Watchdog on cycles without any accepted input request.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed cases, random stream, drain.
  initial begin
    int             close_pct;
    int             gap_max;
    pge_pkg::char_t c;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.char_in <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the stack to the brim, overflow it, then close the largest group.
    send_char(pge_pkg::OPEN_CHAR, 18);
    for (int i = 0; i < DEPTH - 1; i++) send_char(pge_pkg::char_t'(8'h30 + i), 2);
    send_char(8'h71, 18);
    send_char(pge_pkg::OPEN_CHAR, 18);
    send_char(pge_pkg::CLOSE_CHAR, 18);

    // Unmatched close on an empty stack, then an empty pair.
    send_char(pge_pkg::CLOSE_CHAR, 18);
    send_char(pge_pkg::OPEN_CHAR, 0);
    send_char(pge_pkg::CLOSE_CHAR, 0);

    // Extreme byte values inside one group.
    send_char(pge_pkg::OPEN_CHAR, 18);
    send_char(8'h00, 18);
    send_char(8'hFF, 18);
    send_char(pge_pkg::CLOSE_CHAR, 18);

    // Nested groups, one of them empty.
    send_char(pge_pkg::OPEN_CHAR, 0);
    send_char(8'h78, 0);
    send_char(pge_pkg::OPEN_CHAR, 0);
    send_char(8'h79, 0);
    send_char(pge_pkg::CLOSE_CHAR, 0);
    send_char(8'h7A, 0);
    send_char(pge_pkg::CLOSE_CHAR, 0);
    send_char(pge_pkg::OPEN_CHAR, 18);
    send_char(pge_pkg::OPEN_CHAR, 18);
    send_char(pge_pkg::CLOSE_CHAR, 18);
    send_char(pge_pkg::CLOSE_CHAR, 18);

    // Unmatched close with characters still on the stack.
    send_char(8'h61, 18);
    send_char(pge_pkg::CLOSE_CHAR, 18);

    // Random stream in segments of differing group length and idling.
    close_pct = 15;
    gap_max   = 18;
    for (int k = 0; k < 123; k++) begin
      if (k % 30 == 0) begin
        close_pct = $urandom_range(3, 30);
        gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 18;
      end
      c = pick_char(close_pct);
      send_char(c, gap_max);
    end
    in_chan.valid <= 1'b0;

    while (groups.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (groups.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
